### hw/rtl/interval_timer_slot_pool_macros.svh
// ----------------------------------------------------------------------------
// interval_timer_slot_pool_macros
// Assertion macros for the interval timer slot pool. Each macro samples on
// clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_SLOT_POOL_MACROS_SVH
`define INTERVAL_TIMER_SLOT_POOL_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge out of reset
`define ITSLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define ITSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ITSLP_ASSERT(lbl, prop, msg)
`define ITSLP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/itslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itslp_pkg
// Types, codes and sizes shared by the interval timer slot pool modules.
// ----------------------------------------------------------------------------
package itslp_pkg;

	// Pool size; slot 0 is reserved to mean "none"
	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ID_W       = 4;
	localparam int TIME_W     = 32;
	// Width that holds both a request id and any slot index
	localparam int IDX_W      = (SLOT_W > ID_W) ? SLOT_W : ID_W;

	// Request type codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_END   = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Request transaction
	typedef struct packed {
		logic              req_type;
		logic [ID_W-1:0]   slot_id;
		logic [TIME_W-1:0] now_us;
	} req_t;

	// Result transaction
	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   granted_slot;
		logic [TIME_W-1:0] elapsed_us;
	} rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic grant;
		logic release_slot;
		logic reject_full;
		logic reject_id;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_start;
		logic free_found;
		logic id_ok;
	} dp_stat_t;

endpackage

### hw/rtl/itslp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itslp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module itslp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/itslp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itslp_ctrl
// Controller for the slot pool: takes a request, then decides in the execute
// cycle whether it grants, releases or rejects.
// ----------------------------------------------------------------------------
module itslp_ctrl
	import itslp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				busy    = 1'b1;
				state_d = S_IDLE;
				if (stat.is_start) begin
					cmd.grant       = stat.free_found;
					cmd.reject_full = !stat.free_found;
				end else begin
					cmd.release_slot = stat.id_ok;
					cmd.reject_id    = !stat.id_ok;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/itslp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itslp_datapath
// Busy bits, start-time memory, free-slot search, id check, elapsed-time
// subtraction and the result register.
// ----------------------------------------------------------------------------
module itslp_datapath
	import itslp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     request,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     done,
	output rsp_t     result
);

	localparam logic [IDX_W:0] COUNT_EXT = (IDX_W + 1)'(SLOT_COUNT);

	req_t              req_q;
	logic [SLOT_COUNT-1:0] slot_busy_q;
	logic [TIME_W-1:0] t0_rdata;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [IDX_W-1:0]  free_ext;
	logic [IDX_W-1:0]  id_ext;
	logic [IDX_W-1:0]  in_id_ext;
	logic              id_in_range;
	logic              id_ok;
	rsp_t              rsp_q;
	logic              done_q;

	// Hold the request for the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
	end

	// Start times: written on grant, read for the incoming id on accept
	assign in_id_ext = IDX_W'(request.slot_id);

	itslp_ram #(
		.WIDTH(TIME_W),
		.DEPTH(SLOT_COUNT)
	) u_start_ram (
		.clk  (clk),
		.we   (cmd.grant),
		.waddr(free_idx),
		.wdata(req_q.now_us),
		.re   (cmd.capture),
		.raddr(in_id_ext[SLOT_W-1:0]),
		.rdata(t0_rdata)
	);

	// Find the lowest free slot from 1 upward
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
			if (!slot_busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign free_ext = IDX_W'(free_idx);

	// Check the end id: nonzero, in range, and in use
	assign id_ext      = IDX_W'(req_q.slot_id);
	assign id_in_range = ({1'b0, id_ext} < COUNT_EXT);
	assign id_ok       = (id_ext != '0) && id_in_range && slot_busy_q[id_ext[SLOT_W-1:0]];

	assign stat.is_start   = (req_q.req_type == REQ_START);
	assign stat.free_found = free_found;
	assign stat.id_ok      = id_ok;

	// Claim and free slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q <= '0;
		end else begin
			if (cmd.grant) begin
				slot_busy_q[free_idx] <= 1'b1;
			end
			if (cmd.release_slot) begin
				slot_busy_q[id_ext[SLOT_W-1:0]] <= 1'b0;
			end
		end
	end

	// Load the result; it holds until the next result is loaded
	always_ff @(posedge clk) begin
		if (cmd.grant) begin
			rsp_q.status       <= ST_OK;
			rsp_q.granted_slot <= free_ext[ID_W-1:0];
			rsp_q.elapsed_us   <= '0;
		end else if (cmd.release_slot) begin
			rsp_q.status       <= ST_OK;
			rsp_q.granted_slot <= '0;
			rsp_q.elapsed_us   <= req_q.now_us - t0_rdata;
		end else if (cmd.reject_full) begin
			rsp_q.status       <= ST_FULL;
			rsp_q.granted_slot <= '0;
			rsp_q.elapsed_us   <= '0;
		end else if (cmd.reject_id) begin
			rsp_q.status       <= ST_BAD_ID;
			rsp_q.granted_slot <= '0;
			rsp_q.elapsed_us   <= '0;
		end
	end

	// Strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.grant | cmd.release_slot | cmd.reject_full | cmd.reject_id;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

### hw/rtl/interval_timer_slot_pool.sv
`timescale 1ns / 1ps
`include "interval_timer_slot_pool_macros.svh"
// ----------------------------------------------------------------------------
// interval_timer_slot_pool
// Pool of stopwatch slots: a start request claims the lowest free slot and
// records the time; an end request returns the elapsed time and frees it.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy is high for the
// one execute cycle that follows, and the result appears on result with done
// high in the cycle after that, for exactly one cycle; it must be taken then,
// since a later result overwrites it. start may be raised again in the cycle
// the result is shown, so a new request is taken once the last has executed.
// The execute cycle serves the start-time memory, read on accept (registered)
// and used on execute. Busy flags clear at reset; no clearing pass runs.
module interval_timer_slot_pool
	import itslp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	itslp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	itslp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	// Every accepted transaction is executed in the next cycle
	`ITSLP_ASSERT_NEXT(a_accept_exec, start && !busy, busy, "accept not followed by execute")
	// Every execute cycle gives exactly one result in the next cycle
	`ITSLP_ASSERT_NEXT(a_exec_done, busy, done && !busy, "execute not followed by result")
	// A result only follows an execute cycle
	`ITSLP_ASSERT(a_done_src, done |-> $past(busy), "result without execute")
	// A rejected transaction carries no slot and no time
	`ITSLP_ASSERT(a_reject_zero, (done && result.status != ST_OK) |-> (result.granted_slot == '0 && result.elapsed_us == '0), "reject with payload")

endmodule
